// ===== rtl/core/bps_pkg.sv =====
`default_nettype none

package bps_pkg;

  // Gravity register reset: 9.7833 m/s^2 in 2^-16 units
  localparam logic [19:0] GRAV_RESET = 20'd641158;
  // Below 1 m/s (256 in 1/256 m/s) no solution is reported
  localparam logic [15:0] SPEED_MIN  = 16'd256;
  // 2 * 1000 mm/m in the denominator of a
  localparam int GRAV_DEN   = 2000;
  // mm * (1/256 m/s)^-1 -> us scaling numerator
  localparam int US_PER_MS  = 1000;
  localparam int CORDIC_STEPS = 18;
  localparam int CORDIC_X0  = 65536;
  localparam int PITCH_MAX  = 102944;
  localparam int QDEPTH     = 4;
  localparam int QAW        = $clog2(QDEPTH);

  localparam logic [16:0] ATAN_TAB [32] = '{
    17'd51472, 17'd30385, 17'd16055, 17'd8150, 17'd4091, 17'd2047, 17'd1024, 17'd512,
    17'd256,   17'd128,   17'd64,    17'd32,   17'd16,   17'd8,    17'd4,    17'd2,
    17'd1,     17'd0,     17'd0,     17'd0,    17'd0,    17'd0,    17'd0,    17'd0,
    17'd0,     17'd0,     17'd0,     17'd0,    17'd0,    17'd0,    17'd0,    17'd0
  };

  // One classified request as it travels from the front end to the solver
  typedef struct packed {
    logic               bad;
    logic [15:0]        spd;
    logic [15:0]        rng;
    logic signed [15:0] hgt;
    logic [19:0]        grav;
    logic [31:0]        rng_sq;
    logic [31:0]        spd_sq;
  } item_t;

  typedef struct packed {
    logic  vld;
    item_t item;
  } q_word_t;

endpackage

`default_nettype wire

// ===== rtl/core/bps_front.sv =====
`default_nettype none

module bps_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [19:0]      cfg_data,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [47:0]      in_tdata,
  output bps_pkg::q_word_t push,
  input  logic             q_full
);
  import bps_pkg::*;

  logic [19:0] grav_r;
  logic        fv_r;
  item_t       item_r;
  logic        take;
  logic        fire;

  assign cfg_ready = 1'b1;
  assign fire      = fv_r && !q_full;
  assign in_tready = !fv_r || !q_full;
  assign take      = in_tvalid && in_tready;
  assign push.vld  = fv_r;
  assign push.item = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grav_r <= GRAV_RESET;
      fv_r   <= 1'b0;
    end else begin
      if (cfg_valid) begin
        grav_r <= cfg_data;
      end
      if (take) begin
        fv_r <= 1'b1;
      end else if (fire) begin
        fv_r <= 1'b0;
      end
    end
  end

  // Classify the trivial cases and square the operands
  always_ff @(posedge clk) begin
    if (take) begin
      item_r.bad    <= (in_tdata[15:0] < SPEED_MIN) || (in_tdata[31:16] == 16'd0);
      item_r.spd    <= in_tdata[15:0];
      item_r.rng    <= in_tdata[31:16];
      item_r.hgt    <= $signed(in_tdata[47:32]);
      item_r.grav   <= grav_r;
      item_r.rng_sq <= 32'(in_tdata[31:16]) * 32'(in_tdata[31:16]);
      item_r.spd_sq <= 32'(in_tdata[15:0]) * 32'(in_tdata[15:0]);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/bps_queue.sv =====
`default_nettype none

module bps_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  bps_pkg::q_word_t push,
  output logic             full,
  output bps_pkg::q_word_t q_out,
  input  logic             pop
);
  import bps_pkg::*;

  item_t          mem_r [QDEPTH];
  logic [QAW-1:0] wr_r;
  logic [QAW-1:0] rd_r;
  logic [QAW:0]   cnt_r;
  logic           do_push;

  assign full       = (cnt_r == (QAW+1)'(QDEPTH));
  assign do_push    = push.vld && !full;
  assign q_out.vld  = (cnt_r != '0);
  assign q_out.item = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_r] <= push.item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wr_r <= (wr_r == QAW'(QDEPTH-1)) ? '0 : wr_r + 1'b1;
      end
      if (pop) begin
        rd_r <= (rd_r == QAW'(QDEPTH-1)) ? '0 : rd_r + 1'b1;
      end
      cnt_r <= cnt_r + (QAW+1)'(do_push) - (QAW+1)'(pop);
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (QAW+1)'(QDEPTH)) else $error("queue count above depth");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> cnt_r != '0) else $error("pop from empty queue");

endmodule

`default_nettype wire

// ===== rtl/core/bps_back.sv =====
`default_nettype none

module bps_back (
  input  logic             clk,
  input  logic             rst_n,
  input  bps_pkg::q_word_t q_in,
  output logic             q_pop,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [47:0]      out_tdata,
  output logic             out_tuser
);
  import bps_pkg::*;

  localparam int DIVA_N = 25;
  localparam int SQ1_N  = 26;
  localparam int DIVC_N = 32;
  localparam int SQ2_N  = 32;
  localparam int DIVT_N = 24;
  localparam int NCOR   = (CORDIC_STEPS < 32) ? CORDIC_STEPS : 32;
  localparam int LAT    = DIVA_N + SQ1_N + DIVC_N + SQ2_N + DIVT_N + NCOR + 13;

  typedef struct packed {
    logic bad; logic [15:0] spd; logic [15:0] rng; logic signed [15:0] hgt;
    logic [31:0] rng_sq; logic [51:0] gd2; logic [42:0] dd;
  } sa_t;
  typedef struct packed {
    logic bad; logic [15:0] spd; logic [15:0] rng; logic signed [15:0] hgt;
    logic [31:0] rng_sq; logic [59:0] rem; logic [42:0] dvs; logic [DIVA_N-1:0] q;
  } da_t;
  typedef struct packed {
    logic bad; logic [15:0] spd; logic [15:0] rng; logic [31:0] rng_sq;
    logic [24:0] aq; logic signed [26:0] b;
  } sc_t;
  typedef struct packed {
    logic bad; logic [15:0] spd; logic [15:0] rng; logic [31:0] rng_sq;
    logic signed [26:0] b; logic signed [52:0] m;
  } sd_t;
  typedef struct packed {
    logic bad; logic [15:0] spd; logic [15:0] rng; logic signed [26:0] b;
    logic [51:0] n; logic [51:0] res;
  } s1_t;
  typedef struct packed {
    logic bad; logic [15:0] spd; logic [15:0] rng; logic sgn;
    logic [26:0] absn; logic [26:0] den;
  } sf_t;
  typedef struct packed {
    logic bad; logic [15:0] spd; logic [15:0] rng; logic sgn; logic sat;
    logic [42:0] rem; logic [26:0] dvs; logic [DIVC_N-1:0] q;
  } dc_t;
  typedef struct packed {
    logic bad; logic [15:0] spd; logic [15:0] rng; logic sgn; logic [31:0] mag;
  } sh_t;
  typedef struct packed {
    logic bad; logic [15:0] spd; logic [15:0] rng; logic sgn; logic [31:0] mag;
    logic [63:0] n; logic [63:0] res;
  } s2_t;
  typedef struct packed {
    logic bad; logic [15:0] spd; logic sgn; logic [31:0] mag; logic [47:0] ds;
  } sj_t;
  typedef struct packed {
    logic bad; logic [15:0] spd; logic sgn; logic [31:0] mag; logic [49:0] nt;
  } sk_t;
  typedef struct packed {
    logic bad; logic [15:0] spd; logic sgn; logic [31:0] mag; logic sat;
    logic [49:0] rem; logic [DIVT_N-1:0] q;
  } dt_t;
  typedef struct packed {
    logic bad; logic [23:0] tm;
    logic signed [33:0] x; logic signed [33:0] y; logic signed [18:0] z;
  } cr_t;

  logic           en;
  logic [LAT-1:0] vld_r;
  sa_t            sa_r;
  da_t            da_r [DIVA_N+1];
  sc_t            sc_r;
  sd_t            sd_r;
  s1_t            s1_r [SQ1_N+1];
  sf_t            sf_r;
  dc_t            dc_r [DIVC_N+1];
  sh_t            sh_r;
  s2_t            s2_r [SQ2_N+1];
  sj_t            sj_r;
  sk_t            sk_r;
  dt_t            dt_r [DIVT_N+1];
  cr_t            cr_r [NCOR+1];

  logic               out_valid_r;
  logic               out_sol_r;
  logic [23:0]        out_time_r;
  logic signed [17:0] out_pitch_r;

  logic [59:0]        a_num;
  logic               a_ovf;
  logic signed [54:0] e_dq;
  logic signed [27:0] f_n2;
  logic               g_sat;
  logic [57:0]        k_t1;
  logic               l_sat;
  logic signed [18:0] fin_z;

  assign en    = !out_valid_r || out_tready;
  assign q_pop = en && q_in.vld;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], q_pop};
    end
  end

  // Products for a = g*d^2*256 / (2000*v^2)
  always_ff @(posedge clk) begin
    if (en) begin
      sa_r.bad    <= q_in.item.bad;
      sa_r.spd    <= q_in.item.spd;
      sa_r.rng    <= q_in.item.rng;
      sa_r.hgt    <= q_in.item.hgt;
      sa_r.rng_sq <= q_in.item.rng_sq;
      sa_r.gd2    <= 52'(q_in.item.grav) * 52'(q_in.item.rng_sq);
      sa_r.dd     <= 43'(q_in.item.spd_sq) * 43'(GRAV_DEN);
    end
  end

  // Flag a too large before dividing: the quotient then needs only DIVA_N bits
  assign a_num = {sa_r.gd2, 8'b0};
  assign a_ovf = {8'b0, a_num} >= {sa_r.dd, 25'b0};

  always_ff @(posedge clk) begin
    if (en) begin
      da_r[0].bad    <= sa_r.bad | a_ovf;
      da_r[0].spd    <= sa_r.spd;
      da_r[0].rng    <= sa_r.rng;
      da_r[0].hgt    <= sa_r.hgt;
      da_r[0].rng_sq <= sa_r.rng_sq;
      da_r[0].rem    <= a_num;
      da_r[0].dvs    <= sa_r.dd;
      da_r[0].q      <= '0;
    end
  end

  for (genvar j = 0; j < DIVA_N; j++) begin : g_diva
    localparam int K = DIVA_N - 1 - j;
    logic [67:0] sh;
    logic        fit;
    da_t         stg_nxt;
    assign sh  = 68'(da_r[j].dvs) << K;
    assign fit = {8'b0, da_r[j].rem} >= sh;
    always_comb begin
      stg_nxt = da_r[j];
      if (fit) begin
        stg_nxt.rem = 60'({8'b0, da_r[j].rem} - sh);
      end
      stg_nxt.q[K] = fit;
    end
    always_ff @(posedge clk) begin
      if (en) begin
        da_r[j+1] <= stg_nxt;
      end
    end
  end

  // b = a + h, then a*b, then the discriminant
  always_ff @(posedge clk) begin
    if (en) begin
      sc_r.bad    <= da_r[DIVA_N].bad;
      sc_r.spd    <= da_r[DIVA_N].spd;
      sc_r.rng    <= da_r[DIVA_N].rng;
      sc_r.rng_sq <= da_r[DIVA_N].rng_sq;
      sc_r.aq     <= da_r[DIVA_N].q;
      sc_r.b      <= $signed({2'b00, da_r[DIVA_N].q})
                     + (27'($signed(da_r[DIVA_N].hgt)) <<< 8);
      sd_r.bad    <= sc_r.bad;
      sd_r.spd    <= sc_r.spd;
      sd_r.rng    <= sc_r.rng;
      sd_r.rng_sq <= sc_r.rng_sq;
      sd_r.b      <= sc_r.b;
      sd_r.m      <= 53'($signed({1'b0, sc_r.aq})) * 53'($signed(sc_r.b));
    end
  end

  assign e_dq = $signed({7'b0, sd_r.rng_sq, 16'b0}) - (55'($signed(sd_r.m)) <<< 2);

  always_ff @(posedge clk) begin
    if (en) begin
      s1_r[0].bad <= sd_r.bad | e_dq[54];
      s1_r[0].spd <= sd_r.spd;
      s1_r[0].rng <= sd_r.rng;
      s1_r[0].b   <= sd_r.b;
      s1_r[0].n   <= e_dq[51:0];
      s1_r[0].res <= '0;
    end
  end

  for (genvar j = 0; j < SQ1_N; j++) begin : g_sq1
    logic [51:0] bit_w;
    logic [51:0] t;
    logic        ge;
    s1_t         stg_nxt;
    assign bit_w = 52'(1) << (2 * (SQ1_N - 1 - j));
    assign t     = s1_r[j].res + bit_w;
    assign ge    = s1_r[j].n >= t;
    always_comb begin
      stg_nxt     = s1_r[j];
      stg_nxt.n   = ge ? s1_r[j].n - t : s1_r[j].n;
      stg_nxt.res = ge ? (s1_r[j].res >> 1) + bit_w : s1_r[j].res >> 1;
    end
    always_ff @(posedge clk) begin
      if (en) begin
        s1_r[j+1] <= stg_nxt;
      end
    end
  end

  // Tangent numerator 2b and denominator d + sqrt(disc)
  assign f_n2 = 28'($signed(s1_r[SQ1_N].b)) <<< 1;

  always_ff @(posedge clk) begin
    if (en) begin
      sf_r.bad  <= s1_r[SQ1_N].bad;
      sf_r.spd  <= s1_r[SQ1_N].spd;
      sf_r.rng  <= s1_r[SQ1_N].rng;
      sf_r.sgn  <= f_n2[27];
      sf_r.absn <= f_n2[27] ? 27'(-f_n2) : 27'(f_n2);
      sf_r.den  <= 27'({s1_r[SQ1_N].rng, 8'b0}) + 27'(s1_r[SQ1_N].res[25:0]);
    end
  end

  assign g_sat = 59'({sf_r.absn, 16'b0}) >= {sf_r.den, 32'b0};

  always_ff @(posedge clk) begin
    if (en) begin
      dc_r[0].bad <= sf_r.bad;
      dc_r[0].spd <= sf_r.spd;
      dc_r[0].rng <= sf_r.rng;
      dc_r[0].sgn <= sf_r.sgn;
      dc_r[0].sat <= g_sat;
      dc_r[0].rem <= {sf_r.absn, 16'b0};
      dc_r[0].dvs <= sf_r.den;
      dc_r[0].q   <= '0;
    end
  end

  for (genvar j = 0; j < DIVC_N; j++) begin : g_divc
    localparam int K = DIVC_N - 1 - j;
    logic [58:0] sh;
    logic        fit;
    dc_t         stg_nxt;
    assign sh  = 59'(dc_r[j].dvs) << K;
    assign fit = 59'(dc_r[j].rem) >= sh;
    always_comb begin
      stg_nxt = dc_r[j];
      if (fit) begin
        stg_nxt.rem = 43'(59'(dc_r[j].rem) - sh);
      end
      stg_nxt.q[K] = fit;
    end
    always_ff @(posedge clk) begin
      if (en) begin
        dc_r[j+1] <= stg_nxt;
      end
    end
  end

  // Clamp |tan| to 2^31, then form 2^32 + tan^2 for the secant
  always_ff @(posedge clk) begin
    if (en) begin
      sh_r.bad <= dc_r[DIVC_N].bad;
      sh_r.spd <= dc_r[DIVC_N].spd;
      sh_r.rng <= dc_r[DIVC_N].rng;
      sh_r.sgn <= dc_r[DIVC_N].sgn;
      sh_r.mag <= (dc_r[DIVC_N].sat || dc_r[DIVC_N].q > 32'h8000_0000)
                  ? 32'h8000_0000 : dc_r[DIVC_N].q;
      s2_r[0].bad <= sh_r.bad;
      s2_r[0].spd <= sh_r.spd;
      s2_r[0].rng <= sh_r.rng;
      s2_r[0].sgn <= sh_r.sgn;
      s2_r[0].mag <= sh_r.mag;
      s2_r[0].n   <= 64'(sh_r.mag) * 64'(sh_r.mag) + (64'(1) << 32);
      s2_r[0].res <= '0;
    end
  end

  for (genvar j = 0; j < SQ2_N; j++) begin : g_sq2
    logic [63:0] bit_w;
    logic [63:0] t;
    logic        ge;
    s2_t         stg_nxt;
    assign bit_w = 64'(1) << (2 * (SQ2_N - 1 - j));
    assign t     = s2_r[j].res + bit_w;
    assign ge    = s2_r[j].n >= t;
    always_comb begin
      stg_nxt     = s2_r[j];
      stg_nxt.n   = ge ? s2_r[j].n - t : s2_r[j].n;
      stg_nxt.res = ge ? (s2_r[j].res >> 1) + bit_w : s2_r[j].res >> 1;
    end
    always_ff @(posedge clk) begin
      if (en) begin
        s2_r[j+1] <= stg_nxt;
      end
    end
  end

  // Flight time numerator d*sec*1000/256
  assign k_t1 = 58'(sj_r.ds) * 58'(US_PER_MS);

  always_ff @(posedge clk) begin
    if (en) begin
      sj_r.bad <= s2_r[SQ2_N].bad;
      sj_r.spd <= s2_r[SQ2_N].spd;
      sj_r.sgn <= s2_r[SQ2_N].sgn;
      sj_r.mag <= s2_r[SQ2_N].mag;
      sj_r.ds  <= 48'(s2_r[SQ2_N].rng) * 48'(s2_r[SQ2_N].res[31:0]);
      sk_r.bad <= sj_r.bad;
      sk_r.spd <= sj_r.spd;
      sk_r.sgn <= sj_r.sgn;
      sk_r.mag <= sj_r.mag;
      sk_r.nt  <= k_t1[57:8];
    end
  end

  assign l_sat = sk_r.nt >= 50'({sk_r.spd, 24'b0});

  always_ff @(posedge clk) begin
    if (en) begin
      dt_r[0].bad <= sk_r.bad;
      dt_r[0].spd <= sk_r.spd;
      dt_r[0].sgn <= sk_r.sgn;
      dt_r[0].mag <= sk_r.mag;
      dt_r[0].sat <= l_sat;
      dt_r[0].rem <= sk_r.nt;
      dt_r[0].q   <= '0;
    end
  end

  for (genvar j = 0; j < DIVT_N; j++) begin : g_divt
    localparam int K = DIVT_N - 1 - j;
    logic [49:0] sh;
    logic        fit;
    dt_t         stg_nxt;
    assign sh  = 50'(dt_r[j].spd) << K;
    assign fit = dt_r[j].rem >= sh;
    always_comb begin
      stg_nxt = dt_r[j];
      if (fit) begin
        stg_nxt.rem = dt_r[j].rem - sh;
      end
      stg_nxt.q[K] = fit;
    end
    always_ff @(posedge clk) begin
      if (en) begin
        dt_r[j+1] <= stg_nxt;
      end
    end
  end

  // Arctangent by vectoring from (1.0, tan)
  always_ff @(posedge clk) begin
    if (en) begin
      cr_r[0].bad <= dt_r[DIVT_N].bad;
      cr_r[0].tm  <= dt_r[DIVT_N].sat ? '1 : dt_r[DIVT_N].q;
      cr_r[0].x   <= 34'(CORDIC_X0);
      cr_r[0].y   <= dt_r[DIVT_N].sgn ? -$signed(34'(dt_r[DIVT_N].mag))
                                      : $signed(34'(dt_r[DIVT_N].mag));
      cr_r[0].z   <= '0;
    end
  end

  for (genvar i = 0; i < NCOR; i++) begin : g_cor
    logic signed [33:0] xs;
    logic signed [33:0] ys;
    logic signed [18:0] ang;
    assign xs  = cr_r[i].x >>> i;
    assign ys  = cr_r[i].y >>> i;
    assign ang = $signed(19'(ATAN_TAB[i]));
    always_ff @(posedge clk) begin
      if (en) begin
        cr_r[i+1].bad <= cr_r[i].bad;
        cr_r[i+1].tm  <= cr_r[i].tm;
        if (!cr_r[i].y[33]) begin
          cr_r[i+1].x <= cr_r[i].x + ys;
          cr_r[i+1].y <= cr_r[i].y - xs;
          cr_r[i+1].z <= cr_r[i].z + ang;
        end else begin
          cr_r[i+1].x <= cr_r[i].x - ys;
          cr_r[i+1].y <= cr_r[i].y + xs;
          cr_r[i+1].z <= cr_r[i].z - ang;
        end
      end
    end
  end

  assign fin_z = cr_r[NCOR].z;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= vld_r[LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_sol_r  <= !cr_r[NCOR].bad;
      out_time_r <= cr_r[NCOR].bad ? '0 : cr_r[NCOR].tm;
      if (cr_r[NCOR].bad) begin
        out_pitch_r <= '0;
      end else if (fin_z > 19'(PITCH_MAX)) begin
        out_pitch_r <= 18'(PITCH_MAX);
      end else if (fin_z < -19'(PITCH_MAX)) begin
        out_pitch_r <= -18'(PITCH_MAX);
      end else begin
        out_pitch_r <= 18'(fin_z);
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_sol_r;
  assign out_tdata  = {6'b0, out_pitch_r, out_time_r};

  a_unsolved_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_sol_r |-> out_time_r == '0 && out_pitch_r == '0)
    else $error("unsolvable word carries nonzero payload");
  a_pitch_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_pitch_r <= 18'(PITCH_MAX) && out_pitch_r >= -18'(PITCH_MAX))
    else $error("pitch outside clamp range");

endmodule

`default_nettype wire

// ===== rtl/core/ballistic_pitch_solver_core.sv =====
// Drag-free launch pitch solver.
// in_*  : one solve request per word; tdata = speed (1/256 m/s), range (mm),
//         height (mm, signed), low bits first.
// out_* : one result per request, in order; tuser = solvable, tdata = flight
//         time (us, saturating) then pitch (2^-16 rad, signed).
// cfg_* : gravity (2^-16 m/s^2); write only while no request is in flight.
// Throughput: one word per cycle while the receiver accepts results. Each
// request passes the input register, the queue and the solver pipeline,
// which runs 18 CORDIC steps by default. The pipeline length comes from the
// bit-per-stage dividers (a, tangent, time), the two digit-per-stage square
// roots (discriminant, secant) and one stage per CORDIC step.
// Reset clears the valid flags of the front register, queue and pipeline and
// loads gravity with 9.7833 m/s^2; nothing is emitted until new requests arrive.
// When the receiver stalls, the output register holds its word and the solver
// pipeline freezes; the front end keeps taking requests into its 4-deep queue
// and its input register until both are full, then drops in_tready.
`default_nettype none

module ballistic_pitch_solver_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [19:0] cfg_data,   // gravity
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // muzzle_speed, range_mm, height_mm
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // flight_time_us, pitch_angle, zero pad
  output logic        out_tuser   // solvable
);
  import bps_pkg::*;

  q_word_t push;
  q_word_t q_word;
  logic    q_full;
  logic    q_pop;

  // Front end: register and classify requests, square the operands
  bps_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .push      (push),
    .q_full    (q_full)
  );

  // Decouple the front end from solver stalls
  bps_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .full  (q_full),
    .q_out (q_word),
    .pop   (q_pop)
  );

  // Solver pipeline with output register
  bps_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_in       (q_word),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

`default_nettype wire
